// ===== src/gsga_pkg.sv =====
package gsga_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_BITS = $clog2(MAX_COLS);
  localparam int ROW_BITS = $clog2(MAX_ROWS);
  localparam int CNT_W = 7;
  localparam int GRID_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int GRID_AW = COL_BITS + ROW_BITS;

  localparam int EXP_ENTRIES = 256;
  localparam int EXP_BITS = $clog2(EXP_ENTRIES);
  localparam logic [63:0] EXP_RATIO = 64'd4034748381;

  localparam int POS_W = COL_BITS + 16;
  localparam int SQ_W = 2 * POS_W;
  localparam int NUM_W = SQ_W + 5;

  // actions
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // register indexes
  localparam logic [2:0] REG_COLS = 3'd0;
  localparam logic [2:0] REG_ROWS = 3'd1;
  localparam logic [2:0] REG_XSTEP = 3'd2;
  localparam logic [2:0] REG_YSTEP = 3'd3;

  // result select
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_ADD = 2'd1;
  localparam logic [1:0] OUT_READ = 2'd2;
  localparam logic [1:0] OUT_ZERO = 2'd3;

  typedef logic [15:0] exp_tab_t [EXP_ENTRIES];

  // entry k is exp(-k/16) in q1.15, built by repeated multiplication in q32.32
  function automatic exp_tab_t build_exp_table();
    exp_tab_t t;
    logic [63:0] e;
    e = 64'h1_0000_0000;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      t[k] = 16'((e + 64'h1_0000) >> 17);
      e = (e * EXP_RATIO + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

  typedef struct packed {
    logic                load;
    logic                fac_start;
    logic                fac_axis;
    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic                colfac_we;
    logic                fy_load;
    logic                mrow_load;
    logic                cell_issue;
    logic                row_set;
    logic                valid_clear;
    logic                read_issue;
    logic [1:0]          out_sel;
  } gsga_cmd_t;

  typedef struct packed {
    logic                fac_done;
    logic [COL_BITS-1:0] col_last;
    logic [ROW_BITS-1:0] row_last;
  } gsga_stat_t;

endpackage

// ===== src/gaussian_splat_grid_accumulator.sv =====
// channel   direction  beat marked by          payload
// command   in         start & !busy           action, center_x/y, spread_x/y, peak,
//                                              cell_col, cell_row
// result    out        done (one cycle)        cell_value, saturated
// config    in         cfg_valid & cfg_ready   cfg_index, cfg_data
//
// an add runs one shared factor unit with an 8-step divider per column and row (nc, nr
// active columns and rows), then one cell per cycle through the grid memory port. read
// steps through S_READ and S_RDONE; clear and unknown answer straight from idle.
// rst is synchronous; the grid reads as zero after reset through per-row valid bits.
// the result is shown for one cycle and cannot be stalled; cfg_ready is always high.
module gaussian_splat_grid_accumulator
  import gsga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          action,
  input  logic [15:0]         center_x,
  input  logic [15:0]         center_y,
  input  logic [15:0]         spread_x,
  input  logic [15:0]         spread_y,
  input  logic signed [31:0]  peak,
  input  logic [5:0]          cell_col,
  input  logic [5:0]          cell_row,
  output logic                done,
  output logic signed [31:0]  cell_value,
  output logic                saturated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  gsga_cmd_t  cmd;
  gsga_stat_t stat;

  assign cfg_ready = 1'b1;

  gsga_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  gsga_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .center_x   (center_x),
    .center_y   (center_y),
    .spread_x   (spread_x),
    .spread_y   (spread_y),
    .peak       (peak),
    .cell_col   (COL_BITS'(cell_col)),
    .cell_row   (ROW_BITS'(cell_row)),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .cell_value (cell_value),
    .saturated  (saturated)
  );

endmodule

// ===== src/gsga_ram.sv =====
module gsga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/gsga_factor.sv =====
module gsga_factor
  import gsga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [COL_BITS-1:0] idx,
  input  logic [15:0]         step,
  input  logic [15:0]         centre,
  input  logic [15:0]         spread,
  output logic                done,
  output logic [15:0]         factor
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_DIST = 3'd1;
  localparam logic [2:0] F_SQ   = 3'd2;
  localparam logic [2:0] F_NUM  = 3'd3;
  localparam logic [2:0] F_CHK  = 3'd4;
  localparam logic [2:0] F_DIV  = 3'd5;
  localparam logic [2:0] F_OUT  = 3'd6;

  logic [2:0]          state;
  logic [POS_W-1:0]    pos;
  logic [15:0]         c;
  logic [15:0]         s;
  logic [POS_W-1:0]    d;
  logic [SQ_W-1:0]     d2;
  logic [31:0]         s2;
  logic [NUM_W-1:0]    rem;
  logic [NUM_W-1:0]    den;
  logic                ovf;
  logic [EXP_BITS-1:0] q;
  logic [$clog2(EXP_BITS)-1:0] bitn;
  logic [NUM_W-1:0]    den_sh;

  assign den_sh = den << bitn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        F_IDLE: begin
          if (start) begin
            pos <= POS_W'(idx * step);
            c <= centre;
            s <= (spread == 16'd0) ? 16'd1 : spread;
            state <= F_DIST;
          end
        end
        F_DIST: begin
          d <= (pos >= POS_W'(c)) ? pos - POS_W'(c) : POS_W'(c) - pos;
          state <= F_SQ;
        end
        F_SQ: begin
          d2 <= d * d;
          s2 <= s * s;
          state <= F_NUM;
        end
        F_NUM: begin
          rem <= (NUM_W'(d2) << 4) + NUM_W'(s2);
          den <= NUM_W'(s2) << 1;
          state <= F_CHK;
        end
        F_CHK: begin
          // quotient would reach past the table
          ovf <= rem >= (den << EXP_BITS);
          q <= '0;
          bitn <= ($clog2(EXP_BITS))'(EXP_BITS - 1);
          state <= F_DIV;
        end
        F_DIV: begin
          if (rem >= den_sh) begin
            rem <= rem - den_sh;
            q[bitn] <= 1'b1;
          end
          if (bitn == '0) begin
            state <= F_OUT;
          end else begin
            bitn <= bitn - 1'b1;
          end
        end
        F_OUT: begin
          factor <= ovf ? 16'd0 : EXP_TABLE[q];
          done <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/gsga_datapath.sv =====
module gsga_datapath
  import gsga_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  gsga_cmd_t           cmd,
  output gsga_stat_t          stat,
  input  logic [15:0]         center_x,
  input  logic [15:0]         center_y,
  input  logic [15:0]         spread_x,
  input  logic [15:0]         spread_y,
  input  logic signed [31:0]  peak,
  input  logic [COL_BITS-1:0] cell_col,
  input  logic [ROW_BITS-1:0] cell_row,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                done,
  output logic signed [31:0]  cell_value,
  output logic                saturated
);

  logic [CNT_W-1:0]    col_count, row_count;
  logic [15:0]         x_step, y_step;
  logic [15:0]         cx, cy, sx, sy;
  logic                neg;
  logic [31:0]         mag;
  logic [COL_BITS-1:0] rd_col;
  logic [ROW_BITS-1:0] rd_row;
  logic [MAX_ROWS-1:0] row_valid;
  logic                sat_flag;

  logic                fac_done;
  logic [15:0]         fac_out;
  logic [15:0]         fy;
  logic [47:0]         mrow;

  logic [15:0]         fx_rd;
  logic [31:0]         g_rd;
  logic [GRID_AW-1:0]  g_raddr;
  logic                g_we;
  logic [GRID_AW-1:0]  g_waddr;
  logic [31:0]         g_wdata;

  logic                p1_valid, p2_valid;
  logic [GRID_AW-1:0]  p1_addr, p2_addr;
  logic                p1_rowok;
  logic signed [31:0]  p2_cell;
  logic [63:0]         p2_prod;
  logic                rd_ok;

  logic [CNT_W-1:0]    nc, nr;
  logic [33:0]         rnd;
  logic signed [35:0]  contrib, sum;
  logic                hi, lo;

  always_comb begin
    nc = (col_count < CNT_W'(2)) ? CNT_W'(2) :
         (col_count > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : col_count;
    nr = (row_count < CNT_W'(2)) ? CNT_W'(2) :
         (row_count > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_count;
  end

  assign stat.col_last = COL_BITS'(nc - 1'b1);
  assign stat.row_last = ROW_BITS'(nr - 1'b1);
  assign stat.fac_done = fac_done;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= CNT_W'(MAX_COLS);
      row_count <= CNT_W'(MAX_ROWS);
      x_step <= 16'd256;
      y_step <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLS:  col_count <= cfg_data[CNT_W-1:0];
        REG_ROWS:  row_count <= cfg_data[CNT_W-1:0];
        REG_XSTEP: x_step <= cfg_data;
        REG_YSTEP: y_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // item fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= center_x;
      cy <= center_y;
      sx <= spread_x;
      sy <= spread_y;
      neg <= peak[31];
      mag <= peak[31] ? 32'(-peak) : 32'(peak);
      rd_col <= cell_col;
      rd_row <= cell_row;
    end
  end

  // a row whose bit is clear reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.valid_clear ||
                 (cfg_we && (cfg_index == REG_COLS || cfg_index == REG_ROWS))) begin
      row_valid <= '0;
    end else if (cmd.row_set) begin
      row_valid[cmd.row] <= 1'b1;
    end
  end

  gsga_factor u_factor (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.fac_start),
    .idx    (cmd.fac_axis ? COL_BITS'(cmd.row) : cmd.col),
    .step   (cmd.fac_axis ? y_step : x_step),
    .centre (cmd.fac_axis ? cy : cx),
    .spread (cmd.fac_axis ? sy : sx),
    .done   (fac_done),
    .factor (fac_out)
  );

  always_ff @(posedge clk) begin
    if (cmd.fy_load) begin
      fy <= fac_out;
    end
    if (cmd.mrow_load) begin
      mrow <= mag * fy;
    end
  end

  gsga_ram #(.WIDTH(16), .DEPTH(MAX_COLS)) u_colfac (
    .clk   (clk),
    .we    (cmd.colfac_we),
    .waddr (cmd.col),
    .wdata (fac_out),
    .raddr (cmd.col),
    .rdata (fx_rd)
  );

  assign g_raddr = cmd.read_issue ? {rd_row, rd_col} : {cmd.row, cmd.col};

  gsga_ram #(.WIDTH(32), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (g_wdata),
    .raddr (g_raddr),
    .rdata (g_rd)
  );

  // cell pipeline: read, multiply, accumulate and write
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= cmd.cell_issue;
      p2_valid <= p1_valid;
    end
    p1_addr <= {cmd.row, cmd.col};
    p1_rowok <= row_valid[cmd.row];
    p2_addr <= p1_addr;
    p2_cell <= p1_rowok ? g_rd : 32'sd0;
    p2_prod <= mrow * fx_rd;
  end

  always_comb begin
    rnd = 34'((p2_prod + 64'h2000_0000) >> 30);
    contrib = neg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
    sum = 36'(p2_cell) + contrib;
    hi = sum > 36'sd2147483647;
    lo = sum < -36'sd2147483648;
    g_we = p2_valid;
    g_waddr = p2_addr;
    if (hi) begin
      g_wdata = 32'h7FFF_FFFF;
    end else if (lo) begin
      g_wdata = 32'h8000_0000;
    end else begin
      g_wdata = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sat_flag <= 1'b0;
    end else if (p2_valid && (hi || lo)) begin
      sat_flag <= 1'b1;
    end
    if (cmd.read_issue) begin
      rd_ok <= (rd_col <= stat.col_last) && (rd_row <= stat.row_last) &&
               row_valid[rd_row];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.out_sel != OUT_NONE);
    end
    unique case (cmd.out_sel)
      OUT_ADD: begin
        cell_value <= 32'sd0;
        saturated <= sat_flag;
      end
      OUT_READ: begin
        cell_value <= rd_ok ? g_rd : 32'sd0;
        saturated <= 1'b0;
      end
      OUT_ZERO: begin
        cell_value <= 32'sd0;
        saturated <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/gsga_ctrl.sv =====
module gsga_ctrl
  import gsga_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] action,
  input  gsga_stat_t stat,
  output gsga_cmd_t  cmd,
  output logic       busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COLF  = 4'd1;
  localparam logic [3:0] S_COLW  = 4'd2;
  localparam logic [3:0] S_ROWF  = 4'd3;
  localparam logic [3:0] S_ROWW  = 4'd4;
  localparam logic [3:0] S_MROW  = 4'd5;
  localparam logic [3:0] S_CELL  = 4'd6;
  localparam logic [3:0] S_DRN1  = 4'd7;
  localparam logic [3:0] S_DRN2  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_READ  = 4'd10;
  localparam logic [3:0] S_RDONE = 4'd11;

  logic [3:0]          state, state_next;
  logic [COL_BITS-1:0] col, col_next;
  logic [ROW_BITS-1:0] row, row_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col <= '0;
      row <= '0;
    end else begin
      state <= state_next;
      col <= col_next;
      row <= row_next;
    end
  end

  always_comb begin
    state_next = state;
    col_next = col;
    row_next = row;
    cmd = '0;
    cmd.col = col;
    cmd.row = row;
    cmd.out_sel = OUT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (action)
            ACT_ADD: begin
              col_next = '0;
              row_next = '0;
              state_next = S_COLF;
            end
            ACT_CLEAR: begin
              cmd.valid_clear = 1'b1;
              cmd.out_sel = OUT_ZERO;
            end
            ACT_READ: state_next = S_READ;
            default: cmd.out_sel = OUT_ZERO;
          endcase
        end
      end
      S_COLF: begin
        cmd.fac_start = 1'b1;
        state_next = S_COLW;
      end
      S_COLW: begin
        if (stat.fac_done) begin
          cmd.colfac_we = 1'b1;
          if (col == stat.col_last) begin
            col_next = '0;
            state_next = S_ROWF;
          end else begin
            col_next = col + 1'b1;
            state_next = S_COLF;
          end
        end
      end
      S_ROWF: begin
        cmd.fac_start = 1'b1;
        cmd.fac_axis = 1'b1;
        state_next = S_ROWW;
      end
      S_ROWW: begin
        if (stat.fac_done) begin
          cmd.fy_load = 1'b1;
          state_next = S_MROW;
        end
      end
      S_MROW: begin
        cmd.mrow_load = 1'b1;
        state_next = S_CELL;
      end
      S_CELL: begin
        cmd.cell_issue = 1'b1;
        if (col == stat.col_last) begin
          state_next = S_DRN1;
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_DRN1: state_next = S_DRN2;
      S_DRN2: begin
        cmd.row_set = 1'b1;
        col_next = '0;
        if (row == stat.row_last) begin
          state_next = S_DONE;
        end else begin
          row_next = row + 1'b1;
          state_next = S_ROWF;
        end
      end
      S_DONE: begin
        cmd.out_sel = OUT_ADD;
        state_next = S_IDLE;
      end
      S_READ: begin
        cmd.read_issue = 1'b1;
        state_next = S_RDONE;
      end
      S_RDONE: begin
        cmd.out_sel = OUT_READ;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
